### sv/i2cm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the register-access I2C master.
// No dependencies; imported by the front end, queue, engine and top level.
package i2cm_pkg;

  // Item classes as the front end decodes them.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START_A  = 3'd1,
    PH_START_B  = 3'd2,
    PH_BIT_LOW  = 3'd3,
    PH_BIT_HIGH = 3'd4,
    PH_STOP_A   = 3'd5,
    PH_STOP_B   = 3'd6,
    PH_STOP_C   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_ADDR_W = 3'd0,
    ST_REG    = 3'd1,
    ST_DATA   = 3'd2,
    ST_ADDR_R = 3'd3,
    ST_READ   = 3'd4,
    ST_FINAL  = 3'd5
  } stage_t;

  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_HALF_PERIOD    = 1'b1;

  localparam logic [7:0] RW_READ_BIT = 8'h01;

  // One queued item after classification.
  typedef struct packed {
    cmd_t       kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [4:0] read_count;
    logic       sda_in;
  } entry_t;

  // Byte loaded at the start of each stage; the read stage loads zero and sends nothing.
  function automatic logic [7:0] load_value(stage_t stg, logic [6:0] dev,
                                            logic [7:0] regv, logic [7:0] datv);
    logic [7:0] v;
    case (stg)
      ST_ADDR_W: v = {dev, 1'b0};
      ST_REG:    v = regv;
      ST_DATA:   v = datv;
      ST_ADDR_R: v = {dev, 1'b0} | RW_READ_BIT;
      default:   v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### sv/i2cm_if.sv
`timescale 1ns / 1ps
// Channel interfaces: command/tick items, result items, configuration writes.
// No dependencies.
interface i2cm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic [4:0] read_count;
  logic       sda_in;
  modport source (output valid, kind, reg_addr, write_data, read_count, sda_in,
                  input ready);
  modport sink (input valid, kind, reg_addr, write_data, read_count, sda_in,
                output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       last_byte;
  logic       nack;
  logic       done_res;
  modport source (output valid, scl_out, sda_out, busy_res, read_byte, read_valid,
                  last_byte, nack, done_res, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, read_byte, read_valid,
                last_byte, nack, done_res, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/i2cm_front.sv
`timescale 1ns / 1ps
// Front end: takes items off the input channel, decodes kind, clamps the count.
// Depends on i2cm_pkg and i2cm_if.
module i2cm_front #(
  parameter int MAX_READ = 16
) (
  i2cm_item_if.sink           cmd,
  output logic                q_valid,
  output i2cm_pkg::entry_t    q_entry,
  input  logic                q_ready
);
  import i2cm_pkg::*;

  logic [4:0] cnt;

  always_comb begin
    if (cmd.read_count == 5'd0) begin
      cnt = 5'd1;
    end else if (32'(cmd.read_count) > 32'(MAX_READ)) begin
      cnt = 5'(MAX_READ);
    end else begin
      cnt = cmd.read_count;
    end
  end

  always_comb begin
    // every 2-bit code maps onto cmd_t; kind 3 becomes CMD_NONE
    q_entry.kind       = cmd_t'(cmd.kind);
    q_entry.reg_addr   = cmd.reg_addr;
    q_entry.write_data = cmd.write_data;
    q_entry.read_count = cnt;
    q_entry.sda_in     = cmd.sda_in;
  end

  assign q_valid   = cmd.valid;
  assign cmd.ready = q_ready;

endmodule

### sv/i2cm_queue.sv
`timescale 1ns / 1ps
// Two-entry item queue between the front end and the bus engine.
// Depends on i2cm_pkg.
module i2cm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  i2cm_pkg::entry_t    in_entry,
  output logic                in_ready,
  output logic                out_valid,
  output i2cm_pkg::entry_t    out_entry,
  input  logic                out_ready
);
  import i2cm_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_entry = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

### sv/i2cm_engine.sv
`timescale 1ns / 1ps
// Bus engine: runs start/bit/stop timing per tick item, holds configuration,
// registers one result per item. Depends on i2cm_pkg and i2cm_if.
module i2cm_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  i2cm_pkg::entry_t    q_entry,
  output logic                q_ready,
  i2cm_res_if.source          res,
  i2cm_cfg_if.sink            cfg
);
  import i2cm_pkg::*;

  logic [6:0]  device_address;
  logic [15:0] half_period_ticks;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [4:0]  bytes_left, bytes_left_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] tick_count, tick_count_next;
  logic        is_read, is_read_next;
  logic [7:0]  saved_register, saved_register_next;
  logic [7:0]  saved_data, saved_data_next;
  logic        nack_seen, nack_seen_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;

  logic        fire;
  logic [15:0] hp_eff;
  logic        step;       // tick that reaches the end of a bus step
  logic        ev_valid;
  logic [7:0]  ev_byte;
  logic        ev_last;
  logic        ev_done;

  assign q_ready   = !res.valid || res.ready;
  assign fire      = q_valid && q_ready;
  assign cfg.ready = 1'b1;
  assign hp_eff    = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign step      = fire && (q_entry.kind == CMD_TICK) && (phase != PH_IDLE) &&
                     ({1'b0, tick_count} + 17'd1 >= {1'b0, hp_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= 7'd0;
      half_period_ticks <= 16'd5;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DEVICE_ADDRESS: device_address    <= cfg.data[6:0];
        CFG_HALF_PERIOD:    half_period_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    logic do_load;
    logic do_enter;
    logic [4:0] bl_dec;
    phase_next          = phase;
    stage_next          = stage;
    bit_index_next      = bit_index;
    bytes_left_next     = bytes_left;
    shift_reg_next      = shift_reg;
    tick_count_next     = tick_count;
    is_read_next        = is_read;
    saved_register_next = saved_register;
    saved_data_next     = saved_data;
    nack_seen_next      = nack_seen;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    do_load             = 1'b0;
    do_enter            = 1'b0;
    bl_dec              = (bytes_left != 5'd0) ? bytes_left - 5'd1 : 5'd0;
    if (fire) begin
      case (q_entry.kind)
        CMD_TICK: begin
          if (phase != PH_IDLE && !step) begin
            tick_count_next = tick_count + 16'd1;
          end else if (step) begin
            tick_count_next = 16'd0;
            case (phase)
              PH_START_A: begin
                sda_level_next = 1'b0;
                phase_next     = PH_START_B;
              end
              PH_START_B: begin
                scl_level_next = 1'b0;
                do_load        = 1'b1;
                do_enter       = 1'b1;
              end
              PH_BIT_LOW: begin
                scl_level_next = 1'b1;
                phase_next     = PH_BIT_HIGH;
              end
              PH_BIT_HIGH: begin
                scl_level_next = 1'b0;
                if (stage == ST_READ) begin
                  if (bit_index < 4'd8) shift_reg_next = {shift_reg[6:0], q_entry.sda_in};
                end else if (bit_index == 4'd8 && q_entry.sda_in) begin
                  nack_seen_next = 1'b1;
                end
                bit_index_next = bit_index + 4'd1;
                if (bit_index_next < 4'd9) begin
                  do_enter = 1'b1;
                end else begin
                  case (stage)
                    ST_ADDR_W: begin
                      stage_next = ST_REG;
                      do_load    = 1'b1;
                      do_enter   = 1'b1;
                    end
                    ST_REG: begin
                      if (is_read) begin
                        stage_next     = ST_ADDR_R;
                        phase_next     = PH_STOP_A;
                        sda_level_next = 1'b0;
                      end else begin
                        stage_next = ST_DATA;
                        do_load    = 1'b1;
                        do_enter   = 1'b1;
                      end
                    end
                    ST_DATA: begin
                      stage_next     = ST_FINAL;
                      phase_next     = PH_STOP_A;
                      sda_level_next = 1'b0;
                    end
                    ST_ADDR_R: begin
                      stage_next = ST_READ;
                      do_load    = 1'b1;
                      do_enter   = 1'b1;
                    end
                    default: begin
                      bytes_left_next = bl_dec;
                      if (bl_dec == 5'd0) begin
                        stage_next     = ST_FINAL;
                        phase_next     = PH_STOP_A;
                        sda_level_next = 1'b0;
                      end else begin
                        do_load  = 1'b1;
                        do_enter = 1'b1;
                      end
                    end
                  endcase
                end
              end
              PH_STOP_A: begin
                scl_level_next = 1'b1;
                phase_next     = PH_STOP_B;
              end
              PH_STOP_B: begin
                sda_level_next = 1'b1;
                phase_next     = PH_STOP_C;
              end
              PH_STOP_C: begin
                phase_next = (stage == ST_ADDR_R) ? PH_START_A : PH_IDLE;
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
        CMD_WRITE, CMD_READ: begin
          if (phase == PH_IDLE) begin
            is_read_next        = (q_entry.kind == CMD_READ);
            saved_register_next = q_entry.reg_addr;
            saved_data_next     = q_entry.write_data;
            bytes_left_next     = (q_entry.kind == CMD_READ) ? q_entry.read_count : 5'd0;
            nack_seen_next      = 1'b0;
            stage_next          = ST_ADDR_W;
            bit_index_next      = 4'd0;
            shift_reg_next      = 8'd0;
            tick_count_next     = 16'd0;
            scl_level_next      = 1'b1;
            sda_level_next      = 1'b1;
            phase_next          = PH_START_A;
          end
        end
        default: ;
      endcase
    end
    if (do_load) begin
      shift_reg_next = load_value(stage_next, device_address, saved_register,
                                  saved_data);
      bit_index_next = 4'd0;
    end
    if (do_enter) begin
      phase_next = PH_BIT_LOW;
      if (stage_next == ST_READ) begin
        // master releases SDA for data, then drives ACK or NACK on the last byte
        sda_level_next = (bit_index_next < 4'd8) ? 1'b1 : (bytes_left_next <= 5'd1);
      end else begin
        sda_level_next = (bit_index_next < 4'd8) ? shift_reg_next[~bit_index_next[2:0]]
                                                 : 1'b1;
      end
    end
  end

  // Per-item events
  always_comb begin
    ev_valid = step && (phase == PH_BIT_HIGH) && (stage == ST_READ) &&
               (bit_index == 4'd7);
    ev_byte  = ev_valid ? {shift_reg[6:0], q_entry.sda_in} : 8'd0;
    ev_last  = ev_valid && (bytes_left <= 5'd1);
    ev_done  = step && (phase == PH_STOP_C) && (stage != ST_ADDR_R);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= ST_ADDR_W;
      bit_index      <= 4'd0;
      bytes_left     <= 5'd0;
      shift_reg      <= 8'd0;
      tick_count     <= 16'd0;
      is_read        <= 1'b0;
      saved_register <= 8'd0;
      saved_data     <= 8'd0;
      nack_seen      <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      res.valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      stage          <= stage_next;
      bit_index      <= bit_index_next;
      bytes_left     <= bytes_left_next;
      shift_reg      <= shift_reg_next;
      tick_count     <= tick_count_next;
      is_read        <= is_read_next;
      saved_register <= saved_register_next;
      saved_data     <= saved_data_next;
      nack_seen      <= nack_seen_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      if (fire) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.scl_out    <= scl_level_next;
      res.sda_out    <= sda_level_next;
      res.busy_res   <= (phase_next != PH_IDLE);
      res.read_byte  <= ev_byte;
      res.read_valid <= ev_valid;
      res.last_byte  <= ev_last;
      res.nack       <= nack_seen_next;
      res.done_res   <= ev_done;
    end
  end

  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.read_valid) |-> res.busy_res)
    else $error("read byte reported outside a transaction");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.done_res) |-> (!res.busy_res && res.scl_out && res.sda_out))
    else $error("done without released bus");
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (scl_level && sda_level))
    else $error("bus driven while idle");
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE && stage == ST_READ) |-> (bytes_left != 5'd0))
    else $error("read stage with no bytes left");

endmodule

### sv/i2c_master_register_access_core.sv
`timescale 1ns / 1ps
// I2C master for single-register writes and reads, paced by tick items.
// Depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue, i2cm_engine.
//
// Channels: cmd carries tick items (kind 0) and write/read commands (kind 1/2);
// res returns exactly one result item per cmd item, in order, with the SCL and
// SDA drive levels after that item, busy, nack and any byte received. cfg
// writes device_address (index 0) and half_period_ticks (index 1); it is
// always ready and should only be used while the block is idle.
// Path: an accepted item is first written into the two-entry queue, then the
// bus engine registers its result as it takes the item from the queue, and
// res presents that registered result.
// Throughput: one item per clock while the result register is empty or taken.
// Every bus step lasts half_period_ticks tick items (one if it is 0); a command while busy or
// kind 3 passes without effect but still yields a result.
// Reset: bus released (both lines high), idle, device_address 0,
// half_period_ticks 5, queue empty.
// Stall: when res is not taken the output register holds; the queue keeps
// taking items until both entries are full, then cmd.ready drops.
module i2c_master_register_access_core #(
  parameter int MAX_READ = 16
) (
  input logic          clk,
  input logic          rst,
  i2cm_item_if.sink    cmd,
  i2cm_res_if.source   res,
  i2cm_cfg_if.sink     cfg
);
  import i2cm_pkg::*;

  logic   f_valid;
  entry_t f_entry;
  logic   f_ready;
  logic   h_valid;
  entry_t h_entry;
  logic   h_ready;

  i2cm_front #(.MAX_READ(MAX_READ)) u_front (
    .cmd     (cmd),
    .q_valid (f_valid),
    .q_entry (f_entry),
    .q_ready (f_ready)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_entry  (f_entry),
    .in_ready  (f_ready),
    .out_valid (h_valid),
    .out_entry (h_entry),
    .out_ready (h_ready)
  );

  i2cm_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (h_valid),
    .q_entry (h_entry),
    .q_ready (h_ready),
    .res     (res),
    .cfg     (cfg)
  );

endmodule
